// ----- hw/rtl/spg_pkg.sv -----
// Set partition generator: shared types and constants.
// No dependencies; compiled first.
`default_nettype none

package spg_pkg;

  localparam int unsigned MaxSymbols = 8;
  localparam int unsigned OutBlocks  = 8;
  localparam int unsigned CountW     = 4;
  localparam int unsigned ResetCount = 4;
  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [CountW-1:0] symbol_count;
  } cfg_t;

  typedef struct packed {
    logic restart;
  } req_t;

  typedef struct packed {
    logic [CountW-1:0] block_count;
    logic [7:0]        block_0;
    logic [7:0]        block_1;
    logic [7:0]        block_2;
    logic [7:0]        block_3;
    logic [7:0]        block_4;
    logic [7:0]        block_5;
    logic [7:0]        block_6;
    logic [7:0]        block_7;
    logic              final_partition;
  } rsp_t;

  // front -> back queue head
  typedef struct packed {
    logic valid;
    logic restart;
  } queue_t;

endpackage

`default_nettype wire

// ----- hw/rtl/spg_chan_if.sv -----
// Set partition generator: valid/ready channel interface.
// Payload type is a parameter (types from spg_pkg).
`default_nettype none

interface spg_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/spg_front.sv -----
// Set partition generator front end: accepts request words into a short queue.
// Depends on spg_pkg and spg_chan_if.
`default_nettype none

module spg_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  spg_chan_if.sink             req,
  output spg_pkg::queue_t      q_o,
  input  wire logic            pop_i
);

  localparam int unsigned Depth = spg_pkg::QueueDepth;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign req.ready   = (cnt_q != CntW'(Depth));
  assign push        = req.valid && req.ready;
  assign q_o.valid   = (cnt_q != '0);
  assign q_o.restart = mem_q[rd_ptr_q];
  assign pop         = pop_i && q_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= req.data.restart;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count over depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("pop from empty queue");

  a_cnt_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count did not grow on push");

endmodule

`default_nettype wire

// ----- hw/rtl/spg_back.sv -----
// Set partition generator back end: label state, successor logic, result register.
// Depends on spg_pkg and spg_chan_if.
`default_nettype none

module spg_back #(
  parameter int unsigned MAX_SYMBOLS = spg_pkg::MaxSymbols
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  spg_chan_if.sink             cfg,
  input  wire spg_pkg::queue_t q_i,
  output logic                 pop_o,
  spg_chan_if.source           rsp
);

  localparam int unsigned LW     = $clog2(MAX_SYMBOLS);
  localparam int unsigned CW     = $clog2(MAX_SYMBOLS + 1);
  localparam int unsigned OutSym = (MAX_SYMBOLS < spg_pkg::OutBlocks) ?
                                   MAX_SYMBOLS : spg_pkg::OutBlocks;
  localparam int unsigned RstN   = (spg_pkg::ResetCount > MAX_SYMBOLS) ?
                                   MAX_SYMBOLS : spg_pkg::ResetCount;

  logic [LW-1:0]             lbl_q   [MAX_SYMBOLS];
  logic [LW-1:0]             lbl_d   [MAX_SYMBOLS];
  logic [LW-1:0]             lbl_eff [MAX_SYMBOLS];
  logic [LW-1:0]             nxt     [MAX_SYMBOLS];
  logic [LW-1:0]             pm      [MAX_SYMBOLS];
  logic [CW-1:0]             n_q, n_d;
  logic [LW-1:0]             maxall;
  logic [LW-1:0]             sel, sel_pm, sel_v;
  logic                      found, sel_wrap;
  logic [7:0]                blk     [spg_pkg::OutBlocks];
  logic [spg_pkg::CountW-1:0] cnt;
  logic                      cfg_fire, fire;
  logic                      rsp_valid_q, rsp_valid_d;
  spg_pkg::rsp_t             rsp_q, rsp_d;

  assign cfg.ready = 1'b1;
  assign cfg_fire  = cfg.valid;
  assign fire      = q_i.valid && (!rsp_valid_q || rsp.ready);
  assign pop_o     = fire;

  // effective labels and prefix maxima
  always_comb begin
    for (int k = 0; k < MAX_SYMBOLS; k++) begin
      lbl_eff[k] = q_i.restart ? LW'(k) : lbl_q[k];
    end
    pm[0] = '0;
    for (int k = 1; k < MAX_SYMBOLS; k++) begin
      pm[k] = (lbl_eff[k-1] > pm[k-1]) ? lbl_eff[k-1] : pm[k-1];
    end
  end

  // current partition as block masks
  always_comb begin
    maxall = '0;
    for (int k = 0; k < MAX_SYMBOLS; k++) begin
      if (k < int'(n_q) && lbl_eff[k] > maxall) begin
        maxall = lbl_eff[k];
      end
    end
    cnt = spg_pkg::CountW'(int'(maxall) + 1);
    for (int b = 0; b < spg_pkg::OutBlocks; b++) begin
      blk[b] = '0;
      for (int k = 0; k < OutSym; k++) begin
        if (b < MAX_SYMBOLS && k < int'(n_q) && int'(lbl_eff[k]) == b) begin
          blk[b][k] = 1'b1;
        end
      end
    end
    rsp_d.block_count     = cnt;
    rsp_d.block_0         = blk[0];
    rsp_d.block_1         = blk[1];
    rsp_d.block_2         = blk[2];
    rsp_d.block_3         = blk[3];
    rsp_d.block_4         = blk[4];
    rsp_d.block_5         = blk[5];
    rsp_d.block_6         = blk[6];
    rsp_d.block_7         = blk[7];
    rsp_d.final_partition = (cnt == spg_pkg::CountW'(1));
  end

  // successor: highest symbol that can still move
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int s = 1; s < MAX_SYMBOLS; s++) begin
      if (s < int'(n_q) &&
          (({1'b0, lbl_eff[s]} == {1'b0, pm[s]} + 1'b1) || (lbl_eff[s] < pm[s]))) begin
        found = 1'b1;
        sel   = LW'(s);
      end
    end
    sel_pm   = pm[sel];
    sel_v    = lbl_eff[sel];
    sel_wrap = ({1'b0, sel_v} == {1'b0, sel_pm} + 1'b1);
    for (int j = 0; j < MAX_SYMBOLS; j++) begin
      if (!found) begin
        nxt[j] = LW'(j);
      end else if (j < int'(sel)) begin
        nxt[j] = lbl_eff[j];
      end else if (j == int'(sel)) begin
        nxt[j] = sel_wrap ? '0 : sel_v + 1'b1;
      end else if (j < int'(n_q)) begin
        nxt[j] = LW'(int'(sel_pm) + j - int'(sel));
      end else begin
        nxt[j] = lbl_eff[j];
      end
    end
  end

  always_comb begin
    n_d = n_q;
    for (int k = 0; k < MAX_SYMBOLS; k++) begin
      lbl_d[k] = lbl_q[k];
    end
    if (cfg_fire) begin
      if (cfg.data.symbol_count == '0) begin
        n_d = CW'(1);
      end else if (int'(cfg.data.symbol_count) > MAX_SYMBOLS) begin
        n_d = CW'(MAX_SYMBOLS);
      end else begin
        n_d = CW'(cfg.data.symbol_count);
      end
      for (int k = 0; k < MAX_SYMBOLS; k++) begin
        lbl_d[k] = LW'(k);
      end
    end else if (fire) begin
      for (int k = 0; k < MAX_SYMBOLS; k++) begin
        lbl_d[k] = nxt[k];
      end
    end
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (fire) begin
      rsp_valid_d = 1'b1;
    end else if (rsp.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q         <= CW'(RstN);
      rsp_valid_q <= 1'b0;
      for (int k = 0; k < MAX_SYMBOLS; k++) begin
        lbl_q[k] <= LW'(k);
      end
    end else begin
      n_q         <= n_d;
      rsp_valid_q <= rsp_valid_d;
      for (int k = 0; k < MAX_SYMBOLS; k++) begin
        lbl_q[k] <= lbl_d[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp.valid = rsp_valid_q;
  assign rsp.data  = rsp_q;

  a_first_label: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lbl_q[0] == '0)
    else $error("symbol 0 left block 0");

  a_fire_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> rsp_valid_q)
    else $error("issued word not presented");

  a_final_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && rsp_q.final_partition |-> rsp_q.block_1 == '0)
    else $error("final partition has a second block");

endmodule

`default_nettype wire

// ----- hw/rtl/set_partition_generator_unit.sv -----
// Set partition generator top level: front queue plus back-end successor unit.
// Depends on spg_pkg, spg_chan_if, spg_front, spg_back.
//
// Usage:
//   req : one word per partition wanted; restart=1 first returns to all singletons.
//   rsp : the partition as block masks ordered by smallest member, block_count,
//         and final_partition when every symbol is in one block.
//   cfg : writes symbol_count (0 acts as 1, above MAX_SYMBOLS acts as MAX_SYMBOLS)
//         and restarts the sequence; always ready, write only while idle.
// Path: an accepted request is first written into the queue, then computed into
//   the output register, which presents its result word.
// Throughput: one partition per cycle while rsp.ready is high; the successor is
//   a combinational priority pick over the labels, and the two-entry queue keeps
//   req open while a result waits in the output register.
// Reset: symbol_count 4, all singletons, queue and output empty.
// Stall: a result held by rsp.ready low stays put; one more request enters the
//   queue beside the waiting one and then req.ready drops.
`default_nettype none

module set_partition_generator_unit #(
  parameter int unsigned MAX_SYMBOLS = spg_pkg::MaxSymbols
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  spg_chan_if.sink    cfg,
  spg_chan_if.sink    req,
  spg_chan_if.source  rsp
);

  spg_pkg::queue_t q;
  logic            pop;

  spg_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req),
    .q_o    (q),
    .pop_i  (pop)
  );

  spg_back #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg    (cfg),
    .q_i    (q),
    .pop_o  (pop),
    .rsp    (rsp)
  );

endmodule

`default_nettype wire
